// ===== hdl/bst_pkg.sv =====
package bst_pkg;

	localparam int PATTERN_W = 51;
	localparam int ENTRY_W = 3;
	localparam int ROW_W = 6;
	localparam int WIDTH_W = 6;
	localparam int IDX_W = 6;
	localparam int BAL_W = 5;
	localparam int S_TDATA_W = 64;
	localparam int M_TDATA_W = 56;

	localparam int DEF_MAX_WIDTH = 32;
	localparam int DEF_MAX_ENTRIES = 17;
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 6'd8;

	typedef logic [ENTRY_W-1:0] kink_t;

	// kink codes
	localparam kink_t KC_NONE = 3'd0;
	localparam kink_t KC_ONE = 3'd1;
	localparam kink_t KC_OPEN = 3'd2;
	localparam kink_t KC_MID = 3'd3;
	localparam kink_t KC_CLOSE = 3'd4;

	typedef enum logic [2:0] {
		G_NONE,
		G_ADD,
		G_ILL,
		G_CUP,
		G_CLO,
		G_KLO,
		G_KUP
	} glob_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_UP,
		ST_RD_LO,
		ST_LOOKUP,
		ST_WR_UP,
		ST_WR_LO,
		ST_WALK,
		ST_SHIFT_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic rd_up;
		logic rd_lo;
		logic lookup;
		logic wr_up;
		logic wr_lo;
		logic walk;
		logic shift;
	} cmd_t;

	typedef struct packed {
		logic illegal;
		logic walk_go;
		logic walk_stop;
	} stat_t;

	typedef struct packed {
		logic hit;
		kink_t code;
		logic [BAL_W-1:0] bal;
	} step_t;

	// new upper kink, indexed [upper][lower][cell]
	localparam kink_t TAB_TOP [5][5][2] = '{
		'{'{3'd0, 3'd1}, '{3'd0, 3'd2}, '{3'd0, 3'd2}, '{3'd0, 3'd3}, '{3'd0, 3'd3}},
		'{'{3'd0, 3'd1}, '{3'd0, 3'd2}, '{3'd0, 3'd2}, '{3'd0, 3'd3}, '{3'd0, 3'd3}},
		'{'{3'd0, 3'd2}, '{3'd0, 3'd2}, '{3'd0, 3'd2}, '{3'd0, 3'd2}, '{3'd0, 3'd2}},
		'{'{3'd0, 3'd3}, '{3'd0, 3'd3}, '{3'd0, 3'd3}, '{3'd0, 3'd3}, '{3'd0, 3'd3}},
		'{'{3'd0, 3'd4}, '{3'd0, 3'd3}, '{3'd0, 3'd3}, '{3'd0, 3'd3}, '{3'd0, 3'd3}}
	};

	// new lower kink
	localparam kink_t TAB_BOT [5][5][2] = '{
		'{'{3'd0, 3'd0}, '{3'd1, 3'd4}, '{3'd2, 3'd3}, '{3'd3, 3'd3}, '{3'd4, 3'd4}},
		'{'{3'd0, 3'd0}, '{3'd0, 3'd4}, '{3'd0, 3'd3}, '{3'd0, 3'd3}, '{3'd0, 3'd4}},
		'{'{3'd0, 3'd0}, '{3'd1, 3'd3}, '{3'd2, 3'd3}, '{3'd2, 3'd3}, '{3'd1, 3'd4}},
		'{'{3'd0, 3'd0}, '{3'd1, 3'd3}, '{3'd2, 3'd3}, '{3'd3, 3'd3}, '{3'd4, 3'd4}},
		'{'{3'd0, 3'd0}, '{3'd1, 3'd4}, '{3'd2, 3'd3}, '{3'd3, 3'd3}, '{3'd4, 3'd4}}
	};

	// global action
	localparam glob_t TAB_GLOB [5][5][2] = '{
		'{'{G_NONE, G_NONE}, '{G_NONE, G_NONE}, '{G_NONE, G_NONE}, '{G_NONE, G_NONE},
			'{G_NONE, G_NONE}},
		'{'{G_ADD, G_NONE}, '{G_ILL, G_NONE}, '{G_ILL, G_NONE}, '{G_ILL, G_NONE},
			'{G_ILL, G_NONE}},
		'{'{G_CLO, G_NONE}, '{G_CLO, G_NONE}, '{G_CLO, G_KLO}, '{G_NONE, G_NONE},
			'{G_NONE, G_NONE}},
		'{'{G_NONE, G_NONE}, '{G_NONE, G_NONE}, '{G_NONE, G_KLO}, '{G_NONE, G_NONE},
			'{G_NONE, G_NONE}},
		'{'{G_CUP, G_NONE}, '{G_CUP, G_NONE}, '{G_CUP, G_NONE}, '{G_CUP, G_KUP},
			'{G_CUP, G_KUP}}
	};

	// codes above the table range look up as empty
	function automatic kink_t fold_kink(input kink_t c);
		return (c > KC_CLOSE) ? KC_NONE : c;
	endfunction

endpackage

// ===== hdl/bst_scan.sv =====
module bst_scan (
	input  bst_pkg::kink_t                  code,
	input  logic [bst_pkg::BAL_W-1:0]       bal,
	input  logic                            down,
	input  logic                            closing,
	output bst_pkg::step_t                  step
);
	import bst_pkg::*;

	kink_t s_code;
	kink_t t_code;
	logic bal_zero;

	assign s_code = down ? KC_OPEN : KC_CLOSE;
	assign t_code = down ? KC_CLOSE : KC_OPEN;
	assign bal_zero = (bal == '0);

	// one balance step of the nesting walk
	always_comb begin
		step.hit = 1'b0;
		step.code = code;
		step.bal = bal;
		if (code == s_code) begin
			step.bal = bal + 1'b1;
		end else if (closing && code == KC_MID && bal_zero) begin
			step.hit = 1'b1;
			step.code = s_code;
		end else if (code == t_code && bal_zero) begin
			step.hit = 1'b1;
			step.code = closing ? KC_ONE : KC_MID;
		end else if (code == t_code) begin
			step.bal = bal - 1'b1;
		end
	end

endmodule

// ===== hdl/bst_ctrl.sv =====
module bst_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_free,
	input  bst_pkg::stat_t  stat,
	output bst_pkg::cmd_t   cmd,
	output logic            in_ready,
	output logic            out_load
);
	import bst_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_RD_UP;
			end
			ST_RD_UP: state_d = ST_RD_LO;
			ST_RD_LO: state_d = ST_LOOKUP;
			ST_LOOKUP: state_d = ST_WR_UP;
			ST_WR_UP: begin
				state_d = stat.illegal ? ST_SHIFT_DONE : ST_WR_LO;
			end
			ST_WR_LO: begin
				state_d = stat.walk_go ? ST_WALK : ST_SHIFT_DONE;
			end
			ST_WALK: begin
				if (stat.walk_stop) state_d = ST_SHIFT_DONE;
			end
			ST_SHIFT_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// shift and result load share the last state; shift fires with the load
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_RD_UP: cmd.rd_up = 1'b1;
			ST_RD_LO: cmd.rd_lo = 1'b1;
			ST_LOOKUP: cmd.lookup = 1'b1;
			ST_WR_UP: cmd.wr_up = 1'b1;
			ST_WR_LO: cmd.wr_lo = 1'b1;
			ST_WALK: cmd.walk = 1'b1;
			ST_SHIFT_DONE: begin
				out_load = out_free;
				cmd.shift = out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hdl/bst_dpath.sv =====
module bst_dpath #(
	parameter int MAX_ENTRIES = bst_pkg::DEF_MAX_ENTRIES
) (
	input  logic                             clk,
	input  bst_pkg::cmd_t                    cmd,
	input  logic [bst_pkg::WIDTH_W-1:0]      width,
	input  logic [bst_pkg::PATTERN_W-1:0]    pattern_in,
	input  logic                             top_border_in,
	input  logic                             bottom_border_in,
	input  logic [bst_pkg::ROW_W-1:0]        row_pos,
	input  logic                             even_column,
	input  logic                             cell_filled,
	output bst_pkg::stat_t                   stat,
	output logic [bst_pkg::PATTERN_W-1:0]    pattern_out,
	output logic                             top_border_out,
	output logic                             bottom_border_out,
	output logic                             disconnected,
	output logic                             illegal
);
	import bst_pkg::*;

	localparam int EIW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int PAD_W = MAX_ENTRIES * ENTRY_W;

	kink_t ent_q [MAX_ENTRIES];
	logic [ROW_W-1:0] k_q;
	logic cell_q;
	logic even_q;
	logic top_q;
	logic bot_q;
	kink_t up_q;
	kink_t lo_q;
	glob_t g_q;
	kink_t top_code_q;
	kink_t bot_code_q;
	logic [IDX_W-1:0] idx_q;
	logic [BAL_W-1:0] bal_q;
	logic down_q;
	logic closing_q;

	logic [IDX_W-1:0] half_len;
	logic [IDX_W-1:0] plen;
	logic idx_in;
	kink_t rd_code;
	logic [PAD_W-1:0] pat_pad;
	logic [PAD_W-1:0] pat_pack;
	step_t step;
	logic walk_in;
	logic walk_wr;
	logic is_ill;
	logic shift_en;
	logic next_down;
	logic next_closing;
	logic [IDX_W-1:0] up_start;
	logic [IDX_W-1:0] plen_m1;

	// pattern length w/2+1, capped at the entry count
	assign half_len = IDX_W'(width[WIDTH_W-1:1]) + 1'b1;
	assign plen = (half_len > IDX_W'(MAX_ENTRIES)) ? IDX_W'(MAX_ENTRIES) : half_len;
	assign plen_m1 = plen - 1'b1;

	// single read port; entries past the pattern read empty
	assign idx_in = (idx_q < plen);
	assign rd_code = idx_in ? ent_q[idx_q[EIW-1:0]] : KC_NONE;

	assign pat_pad = PAD_W'(pattern_in);

	assign is_ill = (g_q == G_ILL);
	assign next_down = (g_q == G_CLO) || (g_q == G_KLO);
	assign next_closing = (g_q == G_CUP) || (g_q == G_CLO);
	// in the lower-write cycle idx_q = kp+1, so kp-1 is idx_q-2
	assign up_start = ((idx_q - 2'd2) > plen_m1) ? plen_m1 : (idx_q - 2'd2);

	bst_scan u_scan (
		.code    (rd_code),
		.bal     (bal_q),
		.down    (down_q),
		.closing (closing_q),
		.step    (step)
	);

	assign walk_in = down_q ? idx_in : 1'b1;
	assign walk_wr = cmd.walk && walk_in && step.hit;

	assign stat.illegal = is_ill;
	assign stat.walk_go = (g_q == G_CUP || g_q == G_CLO || g_q == G_KLO || g_q == G_KUP)
		&& (next_down || idx_q != IDX_W'(1));
	assign stat.walk_stop = !walk_in || step.hit || (!down_q && idx_q == '0);

	// last-row shift of odd columns: k > w-2
	assign shift_en = !even_q && ((7'(k_q) + 7'd2) > 7'(width));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				ent_q[i] <= (IDX_W'(i) < plen) ? pat_pad[ENTRY_W*i +: ENTRY_W] : KC_NONE;
			end
		end else if (cmd.shift && shift_en) begin
			ent_q[0] <= KC_NONE;
			for (int i = 1; i < MAX_ENTRIES; i++) begin
				ent_q[i] <= (IDX_W'(i) < plen) ? ent_q[i-1] : KC_NONE;
			end
		end else if (cmd.wr_up && !is_ill && idx_in) begin
			ent_q[idx_q[EIW-1:0]] <= top_code_q;
		end else if (cmd.wr_lo && idx_in) begin
			ent_q[idx_q[EIW-1:0]] <= bot_code_q;
		end else if (walk_wr) begin
			ent_q[idx_q[EIW-1:0]] <= step.code;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			k_q <= row_pos;
			cell_q <= cell_filled;
			even_q <= even_column;
			top_q <= top_border_in;
			bot_q <= bottom_border_in;
			idx_q <= IDX_W'(row_pos[ROW_W-1:1]);
		end
		if (cmd.rd_up) begin
			up_q <= fold_kink(rd_code);
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.rd_lo) begin
			lo_q <= fold_kink(rd_code);
			idx_q <= idx_q - 1'b1;
		end
		if (cmd.lookup) begin
			g_q <= TAB_GLOB[up_q][lo_q][cell_q];
			top_code_q <= TAB_TOP[up_q][lo_q][cell_q];
			bot_code_q <= TAB_BOT[up_q][lo_q][cell_q];
		end
		if (cmd.wr_up) begin
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.wr_lo) begin
			down_q <= next_down;
			closing_q <= next_closing;
			bal_q <= ((g_q == G_CLO) && (lo_q == KC_OPEN)) ? BAL_W'(1) : '0;
			idx_q <= next_down ? (idx_q + 1'b1) : up_start;
		end
		if (cmd.walk) begin
			bal_q <= step.bal;
			idx_q <= down_q ? (idx_q + 1'b1) : (idx_q - 1'b1);
		end
	end

	always_comb begin
		pat_pack = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			pat_pack[ENTRY_W*i +: ENTRY_W] = ent_q[i];
		end
	end

	// result word; the shift lands in the entries on the same edge, so the
	// shifted pattern is formed here
	logic [PAD_W-1:0] pat_final;
	always_comb begin
		pat_final = pat_pack;
		if (shift_en) begin
			pat_final = '0;
			for (int i = 1; i < MAX_ENTRIES; i++) begin
				pat_final[ENTRY_W*i +: ENTRY_W] = (IDX_W'(i) < plen) ? ent_q[i-1] : KC_NONE;
			end
		end
	end

	assign illegal = is_ill;
	assign pattern_out = is_ill ? '0 : PATTERN_W'(pat_final);
	assign top_border_out = !is_ill && (top_q || (k_q == '0 && cell_q));
	assign bottom_border_out = !is_ill
		&& (bot_q || ((7'(k_q) + 7'd1) == 7'(width) && cell_q));
	assign disconnected = !is_ill && (g_q == G_ADD);

endmodule

// ===== hdl/boundary_signature_transition.sv =====
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  s_axis_tdata, 64 bits
// m_axis    out  m_axis_tvalid/m_axis_tready  m_axis_tdata, 56 bits
// cfg       in   cfg_we (no wait)             cfg_wdata, board width
//
// after a word is taken the sequencer reads the upper and lower entries, looks
// up the tables and, unless illegal, writes the upper and lower entries; a close
// or connect then scans the pattern one entry per cycle through the scan unit
// arst_n clears the sequencer and the result valid and sets board width to 8
// the result sits in an output register; a new word is taken while it waits,
// and a finished word holds in the last state until that register frees
module boundary_signature_transition #(
	parameter int MAX_WIDTH = bst_pkg::DEF_MAX_WIDTH,
	parameter int MAX_ENTRIES = bst_pkg::DEF_MAX_ENTRIES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// pattern_in[50:0], top_border_in[51], bottom_border_in[52],
	// row_pos[58:53], even_column[59], cell_filled[60], zeros[63:61]
	input  logic [bst_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// pattern_out[50:0], top_border_out[51], bottom_border_out[52],
	// disconnected[53], illegal[54], zero[55]
	output logic [bst_pkg::M_TDATA_W-1:0]     m_axis_tdata,
	input  logic                              cfg_we,
	input  logic [bst_pkg::WIDTH_W-1:0]       cfg_wdata
);
	import bst_pkg::*;

	// board width register, saturated on write
	logic [WIDTH_W-1:0] width_q;

	// sequencer to datapath
	cmd_t cmd;
	stat_t stat;
	logic out_load;
	logic out_free;

	// result fields from the datapath
	logic [PATTERN_W-1:0] res_pattern;
	logic res_top;
	logic res_bot;
	logic res_disc;
	logic res_ill;

	// output register
	logic out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
		end else if (cfg_we) begin
			width_q <= (cfg_wdata > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : cfg_wdata;
		end
	end

	// output register is free when empty or being drained this cycle
	assign out_free = !out_valid_q || m_axis_tready;

	bst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.out_free (out_free),
		.stat     (stat),
		.cmd      (cmd),
		.in_ready (s_axis_tready),
		.out_load (out_load)
	);

	bst_dpath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dpath (
		.clk               (clk),
		.cmd               (cmd),
		.width             (width_q),
		.pattern_in        (s_axis_tdata[50:0]),
		.top_border_in     (s_axis_tdata[51]),
		.bottom_border_in  (s_axis_tdata[52]),
		.row_pos           (s_axis_tdata[58:53]),
		.even_column       (s_axis_tdata[59]),
		.cell_filled       (s_axis_tdata[60]),
		.stat              (stat),
		.pattern_out       (res_pattern),
		.top_border_out    (res_top),
		.bottom_border_out (res_bot),
		.disconnected      (res_disc),
		.illegal           (res_ill)
	);

	// result valid: set on load, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {1'b0, res_ill, res_disc, res_bot, res_top, res_pattern};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_data_q;

endmodule
